[rtl/wss_pkg.sv]
// Shared types, widths and codes for the windowed sample statistics block.
// No dependencies; every other file in rtl/ imports this package.
`timescale 1ns / 1ps

package wss_pkg;

    // Field and accumulator widths
    localparam int SAMPLE_W    = 24;
    localparam int MAX_WLOG    = 16;
    localparam int WLOG_W      = 5;
    localparam int CNT_W       = MAX_WLOG + 1;
    localparam int SUM_W       = SAMPLE_W + MAX_WLOG;
    localparam int SQ_W        = 2 * SAMPLE_W - 1;
    localparam int SUMSQ_W     = SQ_W + MAX_WLOG;
    localparam int MAG_W       = SUM_W;
    localparam int HALF_W      = (MAG_W + 1) / 2;
    localparam int PROD_W      = 2 * HALF_W;
    localparam int ACC_W       = 2 * MAG_W;
    localparam int STAT_W      = 47;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [WLOG_W-1:0] WLOG_RESET = WLOG_W'(10);

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    // Negated maximum, the empty value of every running maximum
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_NEG_MAX =
        {1'b1, {(SAMPLE_W-2){1'b0}}, 1'b1};
    localparam logic [STAT_W-1:0] STAT_MAX = {STAT_W{1'b1}};

    // Item codes
    localparam logic ACT_SAMPLE    = 1'b0;
    localparam logic ACT_SNAPSHOT  = 1'b1;
    localparam logic KIND_FULL     = 1'b0;
    localparam logic KIND_SNAPSHOT = 1'b1;

    typedef struct packed {
        logic                       action;
        logic signed [SAMPLE_W-1:0] sample;
    } t_in_item;

    typedef struct packed {
        logic                       kind;
        logic signed [SAMPLE_W-1:0] window_min;
        logic signed [SAMPLE_W-1:0] window_max;
        logic signed [SAMPLE_W-1:0] mean_value;
        logic [STAT_W-1:0]          mean_square;
        logic [STAT_W-1:0]          variance_value;
        logic signed [SAMPLE_W-1:0] overall_min;
        logic signed [SAMPLE_W-1:0] overall_max;
    } t_out_item;

    // One closed window or snapshot, handed from the front to the back
    typedef struct packed {
        logic                       kind;
        logic [WLOG_W-1:0]          wlog;
        logic [CNT_W-1:0]           cnt;
        logic signed [SUM_W-1:0]    sum;
        logic [SUMSQ_W-1:0]         sumsq;
        logic signed [SAMPLE_W-1:0] win_lo;
        logic signed [SAMPLE_W-1:0] win_hi;
        logic signed [SAMPLE_W-1:0] all_lo;
        logic signed [SAMPLE_W-1:0] all_hi;
    } t_entry;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SQUARE,
        BK_SHIFT,
        BK_DIV_GO,
        BK_DIV_WAIT,
        BK_FINISH
    } t_back_state;

endpackage

[rtl/wss_front.sv]
// Front end: registers and squares each sample, then accumulates the window.
// Pushes a closed window or snapshot record into the queue. Uses wss_pkg.
`timescale 1ns / 1ps

module wss_front
    import wss_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [WLOG_W-1:0] i_wlog,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_item          i_in_item,
    output logic              o_push,
    output t_entry            o_entry,
    input  logic              i_queue_ready
);

    logic                        r_s1_valid, n_s1_valid;
    logic                        r_s1_action;
    logic signed [SAMPLE_W-1:0]  r_s1_sample;
    logic [SQ_W-1:0]             r_s1_square;
    logic signed [2*SAMPLE_W-1:0] w_square;

    logic [CNT_W-1:0]            r_cnt, n_cnt;
    logic signed [SUM_W-1:0]     r_sum, n_sum;
    logic [SUMSQ_W-1:0]          r_sumsq, n_sumsq;
    logic signed [SAMPLE_W-1:0]  r_win_lo, n_win_lo, r_win_hi, n_win_hi;
    logic signed [SAMPLE_W-1:0]  r_all_lo, n_all_lo, r_all_hi, n_all_hi;

    logic [CNT_W-1:0]            w_upd_cnt, w_threshold;
    logic signed [SUM_W-1:0]     w_sample_ext, w_upd_sum;
    logic [SUMSQ_W-1:0]          w_upd_sumsq;
    logic signed [SAMPLE_W-1:0]  w_upd_win_lo, w_upd_win_hi, w_upd_all_lo, w_upd_all_hi;
    logic                        w_is_snap, w_full, w_go, w_accept;

    assign w_square = i_in_item.sample * i_in_item.sample;
    assign w_accept = i_in_valid && o_in_ready;

    always_comb begin
        w_sample_ext = {{(SUM_W-SAMPLE_W){r_s1_sample[SAMPLE_W-1]}}, r_s1_sample};
        w_upd_cnt    = r_cnt + CNT_W'(1);
        w_threshold  = CNT_W'(1) << i_wlog;
        w_upd_sum    = r_sum + w_sample_ext;
        w_upd_sumsq  = r_sumsq + SUMSQ_W'(r_s1_square);
        w_upd_win_lo = (r_s1_sample < r_win_lo) ? r_s1_sample : r_win_lo;
        w_upd_win_hi = (r_s1_sample > r_win_hi) ? r_s1_sample : r_win_hi;
        w_upd_all_lo = (r_s1_sample < r_all_lo) ? r_s1_sample : r_all_lo;
        w_upd_all_hi = (r_s1_sample > r_all_hi) ? r_s1_sample : r_all_hi;

        w_is_snap  = (r_s1_action == ACT_SNAPSHOT);
        w_full     = (w_upd_cnt >= w_threshold);
        o_push     = r_s1_valid && (w_is_snap || w_full);
        w_go       = !o_push || i_queue_ready;
        o_in_ready = !r_s1_valid || w_go;

        // A snapshot reports the window as it stands; a full window includes this sample
        o_entry.wlog = i_wlog;
        if (w_is_snap) begin
            o_entry.kind   = KIND_SNAPSHOT;
            o_entry.cnt    = r_cnt;
            o_entry.sum    = r_sum;
            o_entry.sumsq  = r_sumsq;
            o_entry.win_lo = r_win_lo;
            o_entry.win_hi = r_win_hi;
            o_entry.all_lo = r_all_lo;
            o_entry.all_hi = r_all_hi;
        end else begin
            o_entry.kind   = KIND_FULL;
            o_entry.cnt    = w_upd_cnt;
            o_entry.sum    = w_upd_sum;
            o_entry.sumsq  = w_upd_sumsq;
            o_entry.win_lo = w_upd_win_lo;
            o_entry.win_hi = w_upd_win_hi;
            o_entry.all_lo = w_upd_all_lo;
            o_entry.all_hi = w_upd_all_hi;
        end

        n_cnt    = r_cnt;
        n_sum    = r_sum;
        n_sumsq  = r_sumsq;
        n_win_lo = r_win_lo;
        n_win_hi = r_win_hi;
        n_all_lo = r_all_lo;
        n_all_hi = r_all_hi;
        if (r_s1_valid && w_go && !w_is_snap) begin
            n_all_lo = w_upd_all_lo;
            n_all_hi = w_upd_all_hi;
            if (w_full) begin
                n_cnt    = '0;
                n_sum    = '0;
                n_sumsq  = '0;
                n_win_lo = SAMPLE_MAX;
                n_win_hi = SAMPLE_NEG_MAX;
            end else begin
                n_cnt    = w_upd_cnt;
                n_sum    = w_upd_sum;
                n_sumsq  = w_upd_sumsq;
                n_win_lo = w_upd_win_lo;
                n_win_hi = w_upd_win_hi;
            end
        end

        if (w_accept) begin
            n_s1_valid = 1'b1;
        end else if (w_go) begin
            n_s1_valid = 1'b0;
        end else begin
            n_s1_valid = r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_cnt      <= '0;
            r_sum      <= '0;
            r_sumsq    <= '0;
            r_win_lo   <= SAMPLE_MAX;
            r_win_hi   <= SAMPLE_NEG_MAX;
            r_all_lo   <= SAMPLE_MAX;
            r_all_hi   <= SAMPLE_NEG_MAX;
        end else begin
            r_s1_valid <= n_s1_valid;
            r_cnt      <= n_cnt;
            r_sum      <= n_sum;
            r_sumsq    <= n_sumsq;
            r_win_lo   <= n_win_lo;
            r_win_hi   <= n_win_hi;
            r_all_lo   <= n_all_lo;
            r_all_hi   <= n_all_hi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_action <= i_in_item.action;
            r_s1_sample <= i_in_item.sample;
            r_s1_square <= w_square[SQ_W-1:0];
        end
    end

endmodule

[rtl/wss_queue.sv]
// Short queue of window records between the front and the back end.
// Register-based, depth QUEUE_DEPTH. Uses wss_pkg.
`timescale 1ns / 1ps

module wss_queue
    import wss_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    output logic   o_ready,
    output logic   o_valid,
    output t_entry o_entry,
    input  logic   i_pop
);

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    t_entry            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [FILL_W-1:0] r_fill;
    logic              w_do_push, w_do_pop;

    assign o_ready   = (r_fill != FILL_W'(QUEUE_DEPTH));
    assign o_valid   = (r_fill != '0);
    assign o_entry   = r_mem[r_rd_ptr];
    assign w_do_push = i_push && o_ready;
    assign w_do_pop  = i_pop && o_valid;

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] ptr);
        ptr_next = (ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= ptr_next(r_wr_ptr);
            end
            if (w_do_pop) begin
                r_rd_ptr <= ptr_next(r_rd_ptr);
            end
            if (w_do_push && !w_do_pop) begin
                r_fill <= r_fill + FILL_W'(1);
            end else if (w_do_pop && !w_do_push) begin
                r_fill <= r_fill - FILL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

[rtl/wss_div.sv]
// Radix-2 restoring divider, one quotient bit per cycle.
// Divides by the window sample count. Uses wss_pkg.
`timescale 1ns / 1ps

module wss_div
    import wss_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [ACC_W-1:0] i_dividend,
    input  logic [CNT_W-1:0] i_divisor,
    output logic             o_done,
    output logic [ACC_W-1:0] o_quotient
);

    localparam int ITER_W = $clog2(ACC_W + 1);

    logic              r_busy, r_done;
    logic [ITER_W-1:0] r_left;
    logic [CNT_W-1:0]  r_rem, r_divisor;
    logic [ACC_W-1:0]  r_work;
    logic [CNT_W:0]    w_trial, w_diff;
    logic              w_fits;

    assign w_trial    = {r_rem, r_work[ACC_W-1]};
    assign w_fits     = (w_trial >= {1'b0, r_divisor});
    assign w_diff     = w_trial - {1'b0, r_divisor};
    assign o_done     = r_done;
    assign o_quotient = r_work;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_left <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_left <= ITER_W'(ACC_W);
            end else if (r_busy) begin
                r_left <= r_left - ITER_W'(1);
                if (r_left == ITER_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Quotient bits shift in from the right as dividend bits leave at the left
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_work    <= i_dividend;
            r_rem     <= '0;
            r_divisor <= i_divisor;
        end else if (r_busy) begin
            r_rem  <= w_fits ? w_diff[CNT_W-1:0] : w_trial[CNT_W-1:0];
            r_work <= {r_work[ACC_W-2:0], w_fits};
        end
    end

endmodule

[rtl/wss_back.sv]
// Back end: turns one window record into the figures of one result item.
// Squares the sum on a shared 20x20 multiplier, shifts or divides, saturates.
// Uses wss_pkg and wss_div.
`timescale 1ns / 1ps

module wss_back
    import wss_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    input  t_entry    i_q_entry,
    output logic      o_q_pop,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    localparam logic signed [SUM_W-1:0] MEAN_HI = SUM_W'(SAMPLE_MAX);
    localparam logic signed [SUM_W-1:0] MEAN_LO = SUM_W'(SAMPLE_MIN);

    t_back_state             r_state, n_state;
    logic [1:0]              r_step, n_step;
    t_entry                  r_ent, n_ent;
    logic [MAG_W-1:0]        r_mag, n_mag;
    logic [PROD_W-1:0]       r_prod, n_prod;
    logic [ACC_W-1:0]        r_acc, n_acc;
    logic signed [SUM_W-1:0] r_mean, n_mean;
    logic [SUMSQ_W-1:0]      r_ms, n_ms;
    logic [ACC_W-1:0]        r_term, n_term;
    logic                    r_out_valid, n_out_valid;
    t_out_item               r_out, n_out;

    logic [HALF_W-1:0]       w_mag_lo, w_mag_hi, w_mul_a, w_mul_b;
    logic [PROD_W-1:0]       w_mul;
    logic [ACC_W-1:0]        w_pp;
    logic [SUM_W-1:0]        w_q_sum, w_q_mag;
    logic signed [SUM_W-1:0] w_ent_sum;
    logic                    w_div_start, w_div_done;
    logic [ACC_W-1:0]        w_div_dividend, w_div_q;
    logic [ACC_W-1:0]        w_ms_ext, w_diff, w_var;
    logic                    w_out_free;

    wss_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (r_ent.cnt),
        .o_done     (w_div_done),
        .o_quotient (w_div_q)
    );

    assign w_mag_lo  = r_mag[HALF_W-1:0];
    assign w_mag_hi  = HALF_W'(r_mag >> HALF_W);
    assign w_mul     = w_mul_a * w_mul_b;
    assign w_q_sum   = i_q_entry.sum;
    assign w_ent_sum = r_ent.sum;
    assign w_q_mag   = w_div_q[SUM_W-1:0];
    assign w_ms_ext  = ACC_W'(r_ms);
    assign w_diff    = w_ms_ext - r_term;
    assign w_var     = (w_ms_ext >= r_term) ? w_diff : '0;
    assign w_out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_comb begin
        // Partial products of the square: low*low, high*low (doubled), high*high
        unique case (r_step)
            2'd0: begin
                w_mul_a = w_mag_lo;
                w_mul_b = w_mag_lo;
                w_pp    = '0;
            end
            2'd1: begin
                w_mul_a = w_mag_hi;
                w_mul_b = w_mag_lo;
                w_pp    = ACC_W'(r_prod);
            end
            2'd2: begin
                w_mul_a = w_mag_hi;
                w_mul_b = w_mag_hi;
                w_pp    = ACC_W'(r_prod) << (HALF_W + 1);
            end
            default: begin
                w_mul_a = w_mag_hi;
                w_mul_b = w_mag_hi;
                w_pp    = ACC_W'(r_prod) << (2 * HALF_W);
            end
        endcase

        unique case (r_step)
            2'd0:    w_div_dividend = ACC_W'(r_mag);
            2'd1:    w_div_dividend = ACC_W'(r_ent.sumsq);
            2'd2:    w_div_dividend = r_acc;
            default: w_div_dividend = r_term;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_ent       = r_ent;
        n_mag       = r_mag;
        n_prod      = r_prod;
        n_acc       = r_acc;
        n_mean      = r_mean;
        n_ms        = r_ms;
        n_term      = r_term;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        o_q_pop     = 1'b0;
        w_div_start = 1'b0;

        unique case (r_state)
            BK_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_ent   = i_q_entry;
                    n_mag   = w_q_sum[SUM_W-1] ? (~w_q_sum + SUM_W'(1)) : w_q_sum;
                    n_acc   = '0;
                    n_step  = '0;
                    n_state = BK_SQUARE;
                end
            end
            BK_SQUARE: begin
                n_prod = w_mul;
                n_acc  = r_acc + w_pp;
                if (r_step == 2'd3) begin
                    n_step = '0;
                    if (r_ent.kind == KIND_FULL) begin
                        n_state = BK_SHIFT;
                    end else if (r_ent.cnt == '0) begin
                        // Empty window: mean, mean square and variance read zero
                        n_mean  = '0;
                        n_ms    = '0;
                        n_term  = '0;
                        n_state = BK_FINISH;
                    end else begin
                        n_state = BK_DIV_GO;
                    end
                end else begin
                    n_step = r_step + 2'd1;
                end
            end
            BK_SHIFT: begin
                n_mean  = w_ent_sum >>> r_ent.wlog;
                n_ms    = r_ent.sumsq >> r_ent.wlog;
                n_term  = r_acc >> {r_ent.wlog, 1'b0};
                n_state = BK_FINISH;
            end
            BK_DIV_GO: begin
                w_div_start = 1'b1;
                n_state     = BK_DIV_WAIT;
            end
            BK_DIV_WAIT: begin
                if (w_div_done) begin
                    unique case (r_step)
                        2'd0: n_mean = w_ent_sum[SUM_W-1] ? (~w_q_mag + SUM_W'(1)) : w_q_mag;
                        2'd1: n_ms   = w_div_q[SUMSQ_W-1:0];
                        default: n_term = w_div_q;
                    endcase
                    if (r_step == 2'd3) begin
                        n_state = BK_FINISH;
                    end else begin
                        n_step  = r_step + 2'd1;
                        n_state = BK_DIV_GO;
                    end
                end
            end
            BK_FINISH: begin
                if (w_out_free) begin
                    n_out_valid      = 1'b1;
                    n_out.kind       = r_ent.kind;
                    n_out.window_min = r_ent.win_lo;
                    n_out.window_max = r_ent.win_hi;
                    if (r_mean > MEAN_HI) begin
                        n_out.mean_value = SAMPLE_MAX;
                    end else if (r_mean < MEAN_LO) begin
                        n_out.mean_value = SAMPLE_MIN;
                    end else begin
                        n_out.mean_value = r_mean[SAMPLE_W-1:0];
                    end
                    n_out.mean_square    = (|r_ms[SUMSQ_W-1:STAT_W]) ? STAT_MAX
                                                                     : r_ms[STAT_W-1:0];
                    n_out.variance_value = (|w_var[ACC_W-1:STAT_W]) ? STAT_MAX
                                                                    : w_var[STAT_W-1:0];
                    n_out.overall_min    = r_ent.all_lo;
                    n_out.overall_max    = r_ent.all_hi;
                    n_state              = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent  <= n_ent;
        r_mag  <= n_mag;
        r_prod <= n_prod;
        r_acc  <= n_acc;
        r_mean <= n_mean;
        r_ms   <= n_ms;
        r_term <= n_term;
        r_out  <= n_out;
    end

endmodule

[rtl/windowed_sample_statistics.sv]
// Windowed sample statistics: the front takes one sample or snapshot transfer per cycle
// while the queue has room. A full-window result passes the front register, the queue
// and the back end's four-step square and shift; a snapshot of a nonempty window takes
// four divisions by the count instead of the shift, 80 quotient bits each. Reset
// (synchronous, active low) empties the window, sets the extremes to +/-8388607 and
// window_log2 to 10; items are accepted right after.
`timescale 1ns / 1ps

module windowed_sample_statistics
    import wss_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Sample and snapshot transfers
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_item          i_in_item,
    // Result transfers
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_item         o_out_item,
    // window_log2 register writes
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [WLOG_W-1:0] i_cfg_data
);

    logic [WLOG_W-1:0] r_window_log2;
    logic [WLOG_W-1:0] w_eff_wlog;

    logic   w_push, w_queue_ready, w_queue_valid, w_pop;
    t_entry w_push_entry, w_pop_entry;

    // Block never refuses: sender must write the register only while the block is idle
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_log2 <= WLOG_RESET;
        end else if (i_cfg_valid) begin
            r_window_log2 <= i_cfg_data;
        end
    end

    // Clamp oversize windows to the largest the accumulators support
    assign w_eff_wlog = (r_window_log2 > WLOG_W'(MAX_WLOG)) ? WLOG_W'(MAX_WLOG)
                                                            : r_window_log2;

    // Front: register, square and accumulate; close windows and take snapshots
    wss_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_wlog        (w_eff_wlog),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_item     (i_in_item),
        .o_push        (w_push),
        .o_entry       (w_push_entry),
        .i_queue_ready (w_queue_ready)
    );

    // Decouple accumulation from the slow figure computation
    wss_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .o_ready (w_queue_ready),
        .o_valid (w_queue_valid),
        .o_entry (w_pop_entry),
        .i_pop   (w_pop)
    );

    // Back: square, shift or divide, saturate, hold the result for transfer
    wss_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_queue_valid),
        .i_q_entry   (w_pop_entry),
        .o_q_pop     (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

[sim/wss_figure_checker.sv]
// Checker for the windowed sample statistics block: watches the sample, result
// and window_log2 channels, predicts each result and compares it. Needs wss_pkg.
`timescale 1ns / 1ps

module wss_figure_checker
    import wss_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  t_in_item          i_in_item,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  t_out_item         i_out_item,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  logic [WLOG_W-1:0] i_cfg_data,
    output int                o_fail_count,
    output int                o_expected_left
);

    localparam longint      S_MAX      = (longint'(1) << (SAMPLE_W - 1)) - 1;
    localparam longint      S_MIN      = -S_MAX - 1;
    localparam logic [63:0] LIM47      = (64'd1 << STAT_W) - 64'd1;
    localparam int          REPORT_MAX = 10;

    // Predicted block state
    logic [WLOG_W-1:0] wlog_reg;
    int unsigned       win_count;
    longint            win_sum;
    logic [63:0]       win_sumsq;
    longint            win_lo;
    longint            win_hi;
    longint            all_lo;
    longint            all_hi;

    t_out_item pending_figures[$];
    int        mismatch_count = 0;

    function automatic logic [63:0] magnitude(longint x);
        return (x < 0) ? 64'(-x) : 64'(x);
    endfunction

    function automatic logic [STAT_W-1:0] clip47(logic [63:0] v);
        return (v > LIM47) ? STAT_MAX : v[STAT_W-1:0];
    endfunction

    // Form one result from the current window and the given figures
    function automatic t_out_item figures(logic kind, longint mean, logic [63:0] msq,
                                          logic [63:0] sq_of_mean);
        t_out_item   f;
        logic [63:0] var_v;
        longint      m;
        var_v = (msq >= sq_of_mean) ? msq - sq_of_mean : 64'd0;
        m     = (mean > S_MAX) ? S_MAX : ((mean < S_MIN) ? S_MIN : mean);
        f.kind           = kind;
        f.window_min     = SAMPLE_W'(win_lo);
        f.window_max     = SAMPLE_W'(win_hi);
        f.mean_value     = SAMPLE_W'(m);
        f.mean_square    = clip47(msq);
        f.variance_value = clip47(var_v);
        f.overall_min    = SAMPLE_W'(all_lo);
        f.overall_max    = SAMPLE_W'(all_hi);
        return f;
    endfunction

    function automatic string figures_text(t_out_item f);
        return $sformatf("kind=%0d min=%0d max=%0d mean=%0d msq=%0d var=%0d omin=%0d omax=%0d",
                         f.kind, f.window_min, f.window_max, f.mean_value, f.mean_square,
                         f.variance_value, f.overall_min, f.overall_max);
    endfunction

    task automatic clear_window();
        win_count = 0;
        win_sum   = 0;
        win_sumsq = 64'd0;
        win_lo    = S_MAX;
        win_hi    = -S_MAX;
    endtask

    // Fold one accepted item into the window; queue the result it causes
    task automatic absorb(t_in_item it);
        longint       v;
        longint       mean;
        logic [63:0]  a;
        logic [63:0]  c;
        logic [63:0]  q;
        logic [63:0]  r;
        logic [63:0]  y;
        logic [63:0]  sq_term;
        logic [127:0] prod;
        logic [127:0] shifted;
        int unsigned  lg;
        if (it.action == ACT_SNAPSHOT) begin
            if (win_count == 0) begin
                pending_figures.push_back(figures(KIND_SNAPSHOT, 0, 64'd0, 64'd0));
            end else begin
                // Truncating division by the count, square of mean without overflow
                a    = magnitude(win_sum);
                c    = 64'(win_count);
                q    = a / c;
                r    = a % c;
                y    = q * a + (r * a) / c;
                mean = longint'(a / c);
                if (win_sum < 0) mean = -mean;
                pending_figures.push_back(figures(KIND_SNAPSHOT, mean, win_sumsq / c, y / c));
            end
        end else begin
            v  = longint'(it.sample);
            lg = (wlog_reg > MAX_WLOG) ? MAX_WLOG : wlog_reg;
            win_count++;
            win_sum   += v;
            win_sumsq += 64'(v * v);
            if (v < win_lo) begin
                win_lo = v;
                if (v < all_lo) all_lo = v;
            end
            if (v > win_hi) begin
                win_hi = v;
                if (v > all_hi) all_hi = v;
            end
            if (win_count >= (32'd1 << lg)) begin
                a       = magnitude(win_sum);
                prod    = 128'(a) * 128'(a);
                shifted = prod >> (2 * lg);
                sq_term = (shifted[127:64] != 0) ? '1 : shifted[63:0];
                mean    = win_sum >>> lg;
                pending_figures.push_back(figures(KIND_FULL, mean, win_sumsq >> lg, sq_term));
                clear_window();
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            wlog_reg = WLOG_RESET;
            all_lo   = S_MAX;
            all_hi   = -S_MAX;
            clear_window();
            pending_figures.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) wlog_reg = i_cfg_data;
            if (i_in_valid && i_in_ready) absorb(i_in_item);
            if (i_out_valid && i_out_ready) begin
                if (pending_figures.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("%0t: unexpected result %s", $realtime,
                                 figures_text(i_out_item));
                end else begin
                    want = pending_figures.pop_front();
                    if (want !== i_out_item) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_MAX) begin
                            $display("%0t: expected %s", $realtime, figures_text(want));
                            $display("%0t: actual   %s", $realtime, figures_text(i_out_item));
                        end
                    end
                end
            end
        end
        o_fail_count    <= mismatch_count;
        o_expected_left <= pending_figures.size();
    end

endmodule

[sim/windowed_sample_statistics_tb.sv]
// Testbench top for windowed_sample_statistics: makes the clock, reset, sample,
// snapshot and window_log2 traffic and gives the verdict. Needs wss_pkg and wss_figure_checker.
`timescale 1ns / 1ps

module windowed_sample_statistics_tb;
    import wss_pkg::*;

    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 145;
    // The slowest result is a snapshot, with its four divisions
    localparam int DRAIN_CYCLES    = 400;
    localparam int HOLD_CYCLES     = 300;
    localparam int END_WAIT        = 20000;
    localparam int RUN_LIMIT_NS    = 8_000_000;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    t_in_item          in_item   = '0;
    logic              out_ready = 1'b0;
    logic              cfg_valid = 1'b0;
    logic [WLOG_W-1:0] cfg_data  = '0;

    logic              o_in_ready;
    logic              o_out_valid;
    t_out_item         o_out_item;
    logic              o_cfg_ready;

    int                fail_count;
    int                expected_left;

    // Idle odds in percent for each side, and the one long result hold-off
    int                in_idle_pct   = 0;
    int                out_idle_pct  = 0;
    logic              hold_request  = 1'b0;
    int                hold_cycles   = 0;

    // window_log2 per random phase: above the maximum, shrinks after the
    // large windows, and both extremes
    int                phase_wlog [PHASES] = '{2, 0, 5, 31, 3, 1, 16, 4, 0, 6, 2, 3};

    always #1 clk = ~clk;

    windowed_sample_statistics u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    wss_figure_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_ready      (o_in_ready),
        .i_in_item       (in_item),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (out_ready),
        .i_out_item      (o_out_item),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (cfg_data),
        .o_fail_count    (fail_count),
        .o_expected_left (expected_left)
    );

    // Result side: stall at random, or hold off for a long stretch once when
    // asked so the block fills up and stalls the sample side
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_request && hold_cycles < HOLD_CYCLES) begin
            out_ready   <= 1'b0;
            hold_cycles <= hold_cycles + 1;
        end else begin
            out_ready <= ($urandom_range(99) >= out_idle_pct);
        end
    end

    // Offer one item after a random gap; return at the edge of its transfer.
    // Valid stays high into the next item unless a gap lowers it.
    task automatic send_item(logic action, logic signed [SAMPLE_W-1:0] value);
        t_in_item it;
        it.action = action;
        it.sample = value;
        while ($urandom_range(99) < in_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (!o_in_ready);
    endtask

    // Stop offering, wait for every expected result, then let in-flight work finish
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_left != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_window_log2(logic [WLOG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int                         phase;
        int                         n;
        int                         guard;
        logic                       action;
        logic signed [SAMPLE_W-1:0] value;

        repeat (9) @(posedge clk);
        rst_n        <= 1'b1;
        in_idle_pct  <= 19;
        out_idle_pct <= 73;
        @(posedge clk);

        // Snapshot of an empty window under the reset window_log2
        send_item(ACT_SNAPSHOT, SAMPLE_MAX);
        settle();
        write_window_log2(WLOG_W'(2));

        // A window of the most negative sample only: maxima stay at their reset value
        repeat (4) send_item(ACT_SAMPLE, SAMPLE_MIN);
        // Both extremes, zero and minus one
        send_item(ACT_SAMPLE, SAMPLE_MAX);
        send_item(ACT_SAMPLE, SAMPLE_MIN);
        send_item(ACT_SAMPLE, SAMPLE_W'(0));
        send_item(ACT_SAMPLE, SAMPLE_W'(-1));
        // Snapshot of a partial window with a negative sum, then complete it
        send_item(ACT_SAMPLE, SAMPLE_W'(1));
        send_item(ACT_SAMPLE, SAMPLE_W'(2));
        send_item(ACT_SAMPLE, SAMPLE_W'(-6));
        send_item(ACT_SNAPSHOT, SAMPLE_MIN);
        send_item(ACT_SAMPLE, SAMPLE_W'(7));
        // Snapshot right after a window closed sees it empty
        send_item(ACT_SNAPSHOT, SAMPLE_W'(0));
        repeat (4) send_item(ACT_SAMPLE, SAMPLE_MAX);
        settle();

        // Window too large acts as the maximum; gather a few extremes
        write_window_log2(WLOG_W'(31));
        send_item(ACT_SAMPLE, SAMPLE_MAX);
        send_item(ACT_SAMPLE, SAMPLE_MIN);
        send_item(ACT_SAMPLE, SAMPLE_MAX);
        send_item(ACT_SAMPLE, SAMPLE_MIN);
        send_item(ACT_SAMPLE, SAMPLE_MIN);
        settle();
        // Shrink the window to one sample: the next sample closes an overfull
        // window and the mean and mean square saturate
        write_window_log2(WLOG_W'(0));
        send_item(ACT_SAMPLE, SAMPLE_MIN);

        // Random phases: first a slow receiver, then a slow sender, then no idling
        for (phase = 0; phase < PHASES; phase++) begin
            settle();
            if (phase == PHASES / 3) begin
                in_idle_pct  <= 73;
                out_idle_pct <= 19;
            end else if (phase == 2 * PHASES / 3) begin
                in_idle_pct  <= 0;
                out_idle_pct <= 0;
            end
            write_window_log2(WLOG_W'(phase_wlog[phase]));
            // Window of one sample: every sample gives a result, so the hold-off fills the block
            if (phase == 1) hold_request <= 1'b1;
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                action = ($urandom_range(99) < 3) ? ACT_SNAPSHOT : ACT_SAMPLE;
                case ($urandom_range(7))
                    0: value = SAMPLE_MAX;
                    1: value = SAMPLE_MIN;
                    2: value = SAMPLE_NEG_MAX;
                    3: value = SAMPLE_W'(int'($urandom_range(16)) - 8);
                    default: value = SAMPLE_W'($urandom());
                endcase
                send_item(action, value);
            end
        end

        // Drain: wait for the last results, then watch for stray ones
        in_valid <= 1'b0;
        guard = 0;
        do begin
            @(posedge clk);
            guard++;
        end while (expected_left != 0 && guard < END_WAIT);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && expected_left == 0) begin
            $display("windowed_sample_statistics: match");
        end else begin
            $display("windowed_sample_statistics: mismatch");
        end
        $finish;
    end

    // Hang guard
    initial begin
        #(RUN_LIMIT_NS);
        $display("windowed_sample_statistics: mismatch");
        $finish;
    end

endmodule
